/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on clk_i, held off while rst_ni is low.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on clk_i, held off while rst_ni is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/efp_pkg.sv */
package efp_pkg;

  localparam int unsigned FRAC_BITS  = 24;
  localparam int unsigned GRID_CELLS = 2097152;

  localparam int unsigned FX_W     = 64;
  localparam int unsigned HALF_W   = FX_W / 2;
  localparam int unsigned PROD_W   = 2 * FX_W;
  localparam int unsigned IDX_W    = 21;
  localparam int unsigned UVAL_W   = 63;
  localparam int unsigned INV_W    = 32;
  localparam int unsigned MUL_LAT  = 4;
  localparam int unsigned NUM_COMP = 5;
  localparam int unsigned NUM_KINDS = 4;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned NUM_CFG  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 63;

  typedef logic signed [FX_W-1:0] fx_t;

  localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

  typedef struct packed {
    fx_t  v;
    logic sat;
  } fxs_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CONS   = 2'd0,
    KIND_FLUX_X = 2'd1,
    KIND_FLUX_Y = 2'd2,
    KIND_FLUX_Z = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_GM1 = 2'd0,
    REG_HOT_EN  = 2'd1,
    REG_HOT_IDX = 2'd2,
    REG_HOT_E   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [INV_W-1:0]  inv_gm1;
    logic              hot_en;
    logic [IDX_W-1:0]  hot_idx;
    logic [UVAL_W-1:0] hot_energy;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    inv_gm1:    32'd41943040,
    hot_en:     1'b0,
    hot_idx:    '0,
    hot_energy: 63'd167772160000000000
  };

  // first member sits in the highest bits, so cell_index lands at bit 0
  typedef struct packed {
    fx_t               vel_z;
    fx_t               vel_y;
    fx_t               vel_x;
    logic [UVAL_W-1:0] pressure;
    logic [UVAL_W-1:0] density;
    logic [IDX_W-1:0]  cell_index;
  } cell_in_t;

  localparam int unsigned IN_BITS    = $bits(cell_in_t);
  localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  typedef struct packed {
    fx_t [NUM_COMP-1:0] comp;
    logic               sat;
  } item_t;

  typedef item_t [NUM_KINDS-1:0] cell_items_t;

  localparam int unsigned OUT_TDATA_W = NUM_COMP * FX_W;
  localparam int unsigned OUT_TUSER_W = KIND_W + 1;

  function automatic fxs_t sat_add(fx_t a, fx_t b);
    fx_t  s;
    fxs_t r;
    s = a + b;
    r.sat = (a[FX_W-1] == b[FX_W-1]) && (s[FX_W-1] != a[FX_W-1]);
    r.v   = r.sat ? (a[FX_W-1] ? FX_MIN : FX_MAX) : s;
    return r;
  endfunction

endpackage

/* rtl/core/efp_mul.sv */
module efp_mul
  import efp_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  fx_t  a_i,
  input  fx_t  b_i,
  output fxs_t res_o
);

  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (FRAC_BITS - 1);

  // stage 1: magnitudes
  logic [FX_W-1:0] ua_d, ub_d, ua_q, ub_q;
  logic            neg1_q, neg2_q, neg3_q;
  // stage 2: partial products
  logic [FX_W-1:0] p_d [4];
  logic [FX_W-1:0] p_q [4];
  // stage 3: rounded magnitude
  logic [PROD_W-1:0] sum_d, sum_q;
  // stage 4: scale and clip
  logic [PROD_W-1:0] q;
  logic [FX_W-1:0]   qlo;
  logic              over;
  fxs_t              res_d, res_q;

  assign ua_d = a_i[FX_W-1] ? FX_W'(-a_i) : FX_W'(a_i);
  assign ub_d = b_i[FX_W-1] ? FX_W'(-b_i) : FX_W'(b_i);

  always_comb begin
    p_d[0] = ua_q[HALF_W-1:0]    * ub_q[HALF_W-1:0];
    p_d[1] = ua_q[HALF_W-1:0]    * ub_q[FX_W-1:HALF_W];
    p_d[2] = ua_q[FX_W-1:HALF_W] * ub_q[HALF_W-1:0];
    p_d[3] = ua_q[FX_W-1:HALF_W] * ub_q[FX_W-1:HALF_W];
  end

  assign sum_d = PROD_W'(p_q[0])
               + (PROD_W'(p_q[1]) << HALF_W)
               + (PROD_W'(p_q[2]) << HALF_W)
               + (PROD_W'(p_q[3]) << FX_W)
               + RND;

  always_comb begin
    q    = sum_q >> FRAC_BITS;
    qlo  = q[FX_W-1:0];
    over = (|q[PROD_W-1:FX_W]) ||
           (neg3_q ? (qlo[FX_W-1] && (|qlo[FX_W-2:0])) : qlo[FX_W-1]);
    res_d.sat = over;
    if (over) begin
      res_d.v = neg3_q ? FX_MIN : FX_MAX;
    end else begin
      res_d.v = neg3_q ? fx_t'(-qlo) : fx_t'(qlo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q   <= ua_d;
      ub_q   <= ub_d;
      neg1_q <= a_i[FX_W-1] ^ b_i[FX_W-1];
      p_q    <= p_d;
      neg2_q <= neg1_q;
      sum_q  <= sum_d;
      neg3_q <= neg2_q;
      res_q  <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/core/efp_pipe.sv */
module efp_pipe
  import efp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cell_in_t    in_cell_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cell_items_t out_items_o
);

  // stage numbers
  localparam int unsigned T_L1   = MUL_LAT;        // first products visible
  localparam int unsigned T_SSQ  = T_L1 + 1;       // |v|^2 second add
  localparam int unsigned T_KIN  = T_L1 + 2;       // rho*|v|^2 issued
  localparam int unsigned T_L2   = T_L1 + MUL_LAT; // second products visible
  localparam int unsigned T_E    = T_KIN + MUL_LAT;
  localparam int unsigned T_EP   = T_E + 1;
  localparam int unsigned T_L3   = T_EP + 1;       // c*(E+p) issued
  localparam int unsigned T_LAST = T_L3 + MUL_LAT + 1;
  localparam int unsigned NSTG   = T_LAST + 1;

  // multiplier slots
  localparam int unsigned M_UU  = 0;
  localparam int unsigned M_VV  = 1;
  localparam int unsigned M_WW  = 2;
  localparam int unsigned M_MU  = 3;
  localparam int unsigned M_MV  = 4;
  localparam int unsigned M_MW  = 5;
  localparam int unsigned M_PG  = 6;
  localparam int unsigned M_RUU = 7;
  localparam int unsigned M_RVV = 8;
  localparam int unsigned M_RWW = 9;
  localparam int unsigned M_MUV = 10;
  localparam int unsigned M_MUW = 11;
  localparam int unsigned M_MWV = 12;
  localparam int unsigned M_MVW = 13;
  localparam int unsigned M_KIN = 14;
  localparam int unsigned M_UEP = 15;
  localparam int unsigned M_VEP = 16;
  localparam int unsigned M_WEP = 17;
  localparam int unsigned NMUL  = 18;

  typedef struct packed {
    logic hot;
    fx_t  rho;
    fx_t  p;
    fx_t  u;
    fx_t  v;
    fx_t  w;
    fxs_t uu;
    fxs_t vv;
    fxs_t ww;
    fxs_t mu;
    fxs_t mv;
    fxs_t mw;
    fxs_t pg;
    fxs_t ssq1;
    fxs_t ssq;
    fxs_t ruu;
    fxs_t rvv;
    fxs_t rww;
    fxs_t muv;
    fxs_t muw;
    fxs_t mwv;
    fxs_t mvw;
    fxs_t e;
    fxs_t ep;
    fxs_t uep;
    fxs_t vep;
    fxs_t wep;
  } stage_t;

  stage_t           s_d [NSTG];
  stage_t           s_q [NSTG];
  logic [NSTG-1:0]  vld_d, vld_q;
  logic             adv;
  logic             in_grid;
  fx_t              ma [NMUL];
  fx_t              mb [NMUL];
  fxs_t             mres [NMUL];

  function automatic fxs_t add_p(fxs_t m, fx_t p);
    fxs_t r;
    r     = sat_add(m.v, p);
    r.sat = r.sat | m.sat;
    return r;
  endfunction

  assign adv         = !vld_q[T_LAST] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[T_LAST];
  assign in_grid     = 32'(in_cell_i.cell_index) < GRID_CELLS;
  assign vld_d       = {vld_q[NSTG-2:0], in_valid_i && in_grid};

  always_comb begin
    ma[M_UU]  = s_q[0].u;            mb[M_UU]  = s_q[0].u;
    ma[M_VV]  = s_q[0].v;            mb[M_VV]  = s_q[0].v;
    ma[M_WW]  = s_q[0].w;            mb[M_WW]  = s_q[0].w;
    ma[M_MU]  = s_q[0].rho;          mb[M_MU]  = s_q[0].u;
    ma[M_MV]  = s_q[0].rho;          mb[M_MV]  = s_q[0].v;
    ma[M_MW]  = s_q[0].rho;          mb[M_MW]  = s_q[0].w;
    ma[M_PG]  = s_q[0].p;            mb[M_PG]  = fx_t'(cfg_i.inv_gm1);
    ma[M_RUU] = s_q[T_L1].rho;       mb[M_RUU] = mres[M_UU].v;
    ma[M_RVV] = s_q[T_L1].rho;       mb[M_RVV] = mres[M_VV].v;
    ma[M_RWW] = s_q[T_L1].rho;       mb[M_RWW] = mres[M_WW].v;
    ma[M_MUV] = mres[M_MU].v;        mb[M_MUV] = s_q[T_L1].v;
    ma[M_MUW] = mres[M_MU].v;        mb[M_MUW] = s_q[T_L1].w;
    ma[M_MWV] = mres[M_MW].v;        mb[M_MWV] = s_q[T_L1].v;
    ma[M_MVW] = mres[M_MV].v;        mb[M_MVW] = s_q[T_L1].w;
    ma[M_KIN] = s_q[T_KIN].rho;      mb[M_KIN] = s_q[T_KIN].ssq.v;
    ma[M_UEP] = s_q[T_L3].u;         mb[M_UEP] = s_q[T_L3].ep.v;
    ma[M_VEP] = s_q[T_L3].v;         mb[M_VEP] = s_q[T_L3].ep.v;
    ma[M_WEP] = s_q[T_L3].w;         mb[M_WEP] = s_q[T_L3].ep.v;
  end

  for (genvar i = 0; i < NMUL; i++) begin : g_mul
    efp_mul u_mul (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (ma[i]),
      .b_i   (mb[i]),
      .res_o (mres[i])
    );
  end

  always_comb begin
    fxs_t  eadd;
    fx_t   kin;
    stage_t te;

    s_d[0]     = '0;
    s_d[0].hot = cfg_i.hot_en && (in_cell_i.cell_index == cfg_i.hot_idx);
    s_d[0].rho = fx_t'(in_cell_i.density);
    s_d[0].p   = fx_t'(in_cell_i.pressure);
    s_d[0].u   = in_cell_i.vel_x;
    s_d[0].v   = in_cell_i.vel_y;
    s_d[0].w   = in_cell_i.vel_z;

    for (int k = 1; k < NSTG; k++) begin
      s_d[k] = s_q[k-1];
    end

    s_d[T_L1+1].uu   = mres[M_UU];
    s_d[T_L1+1].vv   = mres[M_VV];
    s_d[T_L1+1].ww   = mres[M_WW];
    s_d[T_L1+1].mu   = mres[M_MU];
    s_d[T_L1+1].mv   = mres[M_MV];
    s_d[T_L1+1].mw   = mres[M_MW];
    s_d[T_L1+1].pg   = mres[M_PG];
    s_d[T_L1+1].ssq1 = sat_add(mres[M_UU].v, mres[M_VV].v);

    s_d[T_SSQ+1].ssq = sat_add(s_q[T_SSQ].ssq1.v, s_q[T_SSQ].ww.v);

    s_d[T_L2+1].ruu = add_p(mres[M_RUU], s_q[T_L2].p);
    s_d[T_L2+1].rvv = add_p(mres[M_RVV], s_q[T_L2].p);
    s_d[T_L2+1].rww = add_p(mres[M_RWW], s_q[T_L2].p);
    s_d[T_L2+1].muv = mres[M_MUV];
    s_d[T_L2+1].muw = mres[M_MUW];
    s_d[T_L2+1].mwv = mres[M_MWV];
    s_d[T_L2+1].mvw = mres[M_MVW];

    te   = s_q[T_E];
    kin  = {1'b0, mres[M_KIN].v[FX_W-1:1]};
    eadd = sat_add(te.pg.v, kin);
    if (te.hot) begin
      s_d[T_E+1].e.v   = fx_t'(cfg_i.hot_energy);
      s_d[T_E+1].e.sat = 1'b0;
    end else begin
      s_d[T_E+1].e.v   = eadd.v;
      s_d[T_E+1].e.sat = te.uu.sat | te.vv.sat | te.ww.sat | te.ssq1.sat | te.ssq.sat |
                         te.pg.sat | mres[M_KIN].sat | eadd.sat;
    end

    s_d[T_EP+1].ep = sat_add(s_q[T_EP].e.v, s_q[T_EP].p);

    s_d[T_L3+MUL_LAT+1].uep = mres[M_UEP];
    s_d[T_L3+MUL_LAT+1].vep = mres[M_VEP];
    s_d[T_L3+MUL_LAT+1].wep = mres[M_WEP];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q <= s_d;
    end
  end

  // result items of the cell at the tail
  always_comb begin
    stage_t t;
    logic   esat;
    t    = s_q[T_LAST];
    esat = t.e.sat;

    out_items_o[KIND_CONS].comp = {t.e.v, t.mw.v, t.mv.v, t.mu.v, t.rho};
    out_items_o[KIND_CONS].sat  = esat | t.mu.sat | t.mv.sat | t.mw.sat;

    out_items_o[KIND_FLUX_X].comp = {t.uep.v, t.muw.v, t.muv.v, t.ruu.v, t.mu.v};
    out_items_o[KIND_FLUX_X].sat  = esat | t.mu.sat | t.uu.sat | t.ruu.sat | t.muv.sat |
                                    t.muw.sat | t.ep.sat | t.uep.sat;

    out_items_o[KIND_FLUX_Y].comp = {t.vep.v, t.mwv.v, t.rvv.v, t.muv.v, t.mv.v};
    out_items_o[KIND_FLUX_Y].sat  = esat | t.mv.sat | t.mu.sat | t.muv.sat | t.vv.sat |
                                    t.rvv.sat | t.mw.sat | t.mwv.sat | t.ep.sat | t.vep.sat;

    out_items_o[KIND_FLUX_Z].comp = {t.wep.v, t.rww.v, t.mvw.v, t.muw.v, t.mw.v};
    out_items_o[KIND_FLUX_Z].sat  = esat | t.mw.sat | t.mu.sat | t.muw.sat | t.mv.sat |
                                    t.mvw.sat | t.ww.sat | t.rww.sat | t.ep.sat | t.wep.sat;
  end

endmodule

/* rtl/core/efp_ser.sv */
module efp_ser
  import efp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  cell_items_t in_items_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output item_t       out_item_o,
  output kind_e       out_kind_o,
  output logic        out_last_o
);

  localparam logic [KIND_W-1:0] LAST_CNT = KIND_W'(NUM_KINDS - 1);

  cell_items_t       items_q;
  logic [KIND_W-1:0] cnt_d, cnt_q;
  logic              vld_d, vld_q;
  logic              load;

  assign free_o = !vld_q || ((cnt_q == LAST_CNT) && out_ready_i);
  assign load   = in_valid_i && free_o;

  always_comb begin
    vld_d = vld_q;
    cnt_d = cnt_q;
    if (vld_q && out_ready_i) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_CNT) begin
        vld_d = 1'b0;
      end
    end
    if (load) begin
      vld_d = 1'b1;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      items_q <= in_items_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_item_o  = items_q[cnt_q];
  assign out_kind_o  = kind_e'(cnt_q);
  assign out_last_o  = (cnt_q == LAST_CNT);

endmodule

/* rtl/core/euler_flux_from_primitive.sv */
// Channel   Dir  Payload
// s_axis    in   tdata: cell_index, density, pressure, vel_x, vel_y, vel_z
// m_axis    out  tdata: component_1..5; tuser: vector_kind, saturated; tlast: last_of_cell
// cfg       in   cfg_idx_i selects inv_gamma_minus_one, hot_cell_enable,
//                hot_cell_index, hot_cell_energy
//
// The four results of a cell follow one another on the output. Sustained throughput is
// set by the four result transactions per cell on the single output channel; the pipeline
// takes new cells while earlier results are still being sent, unless the tail is blocked.
// Reset loads the register defaults and clears all pipeline valids.
// A cell held at the output freezes the whole 18-stage pipeline; nothing is lost.
`include "assert_macros.svh"

module euler_flux_from_primitive
  import efp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // cell_index, density, pressure, vel_x, vel_y, vel_z, unused pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // component_1, component_2, component_3, component_4, component_5
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // vector_kind, saturated
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tlast
);

  cfg_t        cfg_d, cfg_q;
  cell_in_t    cell_in;
  cell_items_t tail_items;
  logic        tail_vld;
  logic        ser_free;
  item_t       out_item;
  kind_e       out_kind;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_INV_GM1: cfg_d.inv_gm1    = cfg_data_i[INV_W-1:0];
        REG_HOT_EN:  cfg_d.hot_en     = cfg_data_i[0];
        REG_HOT_IDX: cfg_d.hot_idx    = cfg_data_i[IDX_W-1:0];
        REG_HOT_E:   cfg_d.hot_energy = cfg_data_i[UVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cell_in = cell_in_t'(s_axis_tdata[IN_BITS-1:0]);

  efp_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cell_i   (cell_in),
    .out_valid_o (tail_vld),
    .out_ready_i (ser_free),
    .out_items_o (tail_items)
  );

  efp_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tail_vld),
    .in_items_i  (tail_items),
    .free_o      (ser_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item),
    .out_kind_o  (out_kind),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = out_item.comp;
  assign m_axis_tuser = {out_item.sat, out_kind};

  `ASSERT_NEXT(a_kind_steps, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tuser[KIND_W-1:0] == KIND_W'($past(m_axis_tuser[KIND_W-1:0]) + 1'b1)), "result kinds out of order")
  `ASSERT_NEXT(a_cell_starts_cons, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid || (m_axis_tuser[KIND_W-1:0] == KIND_CONS), "new cell does not start with the conserved vector")
  `ASSERT_IMPL(a_stall_blocks_input, tail_vld && !ser_free, !s_axis_tready, "input taken while pipeline tail is blocked")

endmodule

/* verif/euler_flux_from_primitive_tb.sv */
`timescale 1ns / 100ps

module euler_flux_from_primitive_tb;
  import efp_pkg::*;

  localparam int unsigned RESULT_LAT   = 18;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_CELLS = 78;
  localparam int unsigned PAD_W        = IN_TDATA_W - IN_BITS;

  localparam fx_t FX_ONE = 64'sh0000_0000_0100_0000;

  typedef struct packed {
    kind_e              kind;
    fx_t [NUM_COMP-1:0] comp;
    logic               sat;
    logic               last;
  } flux_item_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  // register shadow
  logic [INV_W-1:0]  inv_gm1_q = 32'd41943040;
  logic              hot_en_q  = 1'b0;
  logic [IDX_W-1:0]  hot_idx_q = '0;
  logic [UVAL_W-1:0] hot_e_q   = 63'd167772160000000000;

  logic [IN_TDATA_W-1:0] cell_q[$];
  flux_item_t            flux_q[$];

  bit          clipped;
  bit          tx_hold     = 1'b0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned errors      = 0;
  int unsigned cells_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes  = 0;
  int unsigned cycles      = 0;

  euler_flux_from_primitive i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("euler_flux_from_primitive regression: fail");
      $finish;
    end
  end

  // fixed-point product, round half away from zero, saturating
  function automatic fx_t fx_mul(fx_t a, fx_t b);
    logic         neg;
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] q;
    logic [127:0] lim;
    neg = a[FX_W-1] ^ b[FX_W-1];
    ua  = a[FX_W-1] ? -a : a;
    ub  = b[FX_W-1] ? -b : b;
    q   = ({64'd0, ua} * {64'd0, ub} + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = neg ? {64'd0, 1'b1, 63'd0} : {65'd0, {63{1'b1}}};
    if (q > lim) begin
      clipped = 1'b1;
      return neg ? FX_MIN : FX_MAX;
    end
    return neg ? -fx_t'(q[63:0]) : fx_t'(q[63:0]);
  endfunction

  function automatic fx_t fx_add(fx_t a, fx_t b);
    fx_t s;
    s = a + b;
    if (a[FX_W-1] == b[FX_W-1] && s[FX_W-1] != a[FX_W-1]) begin
      clipped = 1'b1;
      return a[FX_W-1] ? FX_MIN : FX_MAX;
    end
    return s;
  endfunction

  // conserved vector and the three directional fluxes of one cell
  function automatic void predict_cell(cell_in_t c);
    fx_t        rho;
    fx_t        p;
    fx_t        e;
    fx_t        ssq;
    fx_t        kin;
    fx_t        cd;
    fx_t        m;
    fx_t        vel[3];
    bit         e_clip;
    flux_item_t it;
    int         k;
    int         d;
    int         dir;
    rho    = fx_t'({1'b0, c.density});
    p      = fx_t'({1'b0, c.pressure});
    vel[0] = c.vel_x;
    vel[1] = c.vel_y;
    vel[2] = c.vel_z;
    clipped = 1'b0;
    if (hot_en_q && c.cell_index == hot_idx_q) begin
      e = fx_t'({1'b0, hot_e_q});
    end else begin
      ssq = fx_mul(vel[0], vel[0]);
      ssq = fx_add(ssq, fx_mul(vel[1], vel[1]));
      ssq = fx_add(ssq, fx_mul(vel[2], vel[2]));
      kin = fx_mul(rho, ssq);
      kin = {1'b0, kin[FX_W-1:1]};
      e   = fx_add(fx_mul(p, fx_t'({{(FX_W-INV_W){1'b0}}, inv_gm1_q})), kin);
    end
    e_clip = clipped;
    for (k = 0; k < NUM_KINDS; k++) begin
      clipped = e_clip;
      it.kind = kind_e'(k);
      if (k == 0) begin
        it.comp[0] = rho;
        for (d = 0; d < 3; d++) it.comp[d+1] = fx_mul(rho, vel[d]);
        it.comp[4] = e;
      end else begin
        dir = k - 1;
        cd  = vel[dir];
        m   = fx_mul(rho, cd);
        it.comp[0] = m;
        for (d = 0; d < 3; d++) begin
          if (d == dir) begin
            it.comp[d+1] = fx_add(fx_mul(rho, fx_mul(cd, cd)), p);
          end else if (dir == 1 && d == 2) begin
            it.comp[d+1] = fx_mul(fx_mul(rho, vel[2]), cd);
          end else if (d < dir) begin
            it.comp[d+1] = fx_mul(fx_mul(rho, vel[d]), cd);
          end else begin
            it.comp[d+1] = fx_mul(m, vel[d]);
          end
        end
        it.comp[4] = fx_mul(cd, fx_add(e, p));
      end
      it.sat  = clipped;
      it.last = (k == NUM_KINDS - 1);
      flux_q.push_back(it);
    end
  endfunction

  function automatic logic [IN_TDATA_W-1:0] mk_cell(logic [IDX_W-1:0] idx, fx_t rho, fx_t p,
                                                    fx_t vx, fx_t vy, fx_t vz);
    cell_in_t c;
    c.cell_index = idx;
    c.density    = rho[UVAL_W-1:0];
    c.pressure   = p[UVAL_W-1:0];
    c.vel_x      = vx;
    c.vel_y      = vy;
    c.vel_z      = vz;
    return {PAD_W'($urandom), c};
  endfunction

  function automatic fx_t rand_fx();
    fx_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v = '0;
      1: v = FX_MAX;
      2: v = FX_MIN;
      3, 4, 5, 6: v = v >>> $urandom_range(52, 28);
      default: ;
    endcase
    return v;
  endfunction

  function automatic fx_t rand_mag();
    fx_t v;
    v = rand_fx();
    v = v[FX_W-1] ? -v : v;
    return {1'b0, v[UVAL_W-1:0]};
  endfunction

  function automatic logic [IN_TDATA_W-1:0] rand_cell();
    logic [IDX_W-1:0] idx;
    idx = ($urandom_range(5) == 0) ? hot_idx_q : IDX_W'($urandom);
    return mk_cell(idx, rand_mag(), rand_mag(), rand_fx(), rand_fx(), rand_fx());
  endfunction

  // source side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_cell(s_axis_tdata[IN_BITS-1:0]);
        cells_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cell_q.size() != 0 && !tx_hold && $urandom_range(99) >= tx_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= cell_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side
  always @(posedge clk_i) begin
    flux_item_t want;
    fx_t        got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (flux_q.size() == 0) begin
          $error("unexpected result transaction, vector_kind %0d", m_axis_tuser[KIND_W-1:0]);
          errors++;
        end else begin
          want = flux_q.pop_front();
          results_seen++;
          if (m_axis_tuser[KIND_W-1:0] !== want.kind) begin
            $error("vector_kind: expected %0d, got %0d", want.kind, m_axis_tuser[KIND_W-1:0]);
            errors++;
          end
          for (int i = 0; i < NUM_COMP; i++) begin
            got = m_axis_tdata[i*FX_W +: FX_W];
            if (got !== want.comp[i]) begin
              $error("component_%0d: expected %0d, got %0d", i + 1, want.comp[i], got);
              errors++;
            end
          end
          if (m_axis_tuser[KIND_W] !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, m_axis_tuser[KIND_W]);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_cell: expected %0d, got %0d", want.last, m_axis_tlast);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [UVAL_W-1:0] value);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    @(posedge clk_i);
    cfg_we_i  <= 1'b1;
    cfg_idx_i <= idx;
    case (idx)
      REG_INV_GM1: begin
        cfg_data_i <= {junk[CFG_DATA_W-1:INV_W], value[INV_W-1:0]};
        inv_gm1_q  = value[INV_W-1:0];
      end
      REG_HOT_EN: begin
        cfg_data_i <= {junk[CFG_DATA_W-1:1], value[0]};
        hot_en_q   = value[0];
      end
      REG_HOT_IDX: begin
        cfg_data_i <= {junk[CFG_DATA_W-1:IDX_W], value[IDX_W-1:0]};
        hot_idx_q  = value[IDX_W-1:0];
      end
      default: begin
        cfg_data_i <= value;
        hot_e_q    = value;
      end
    endcase
    cfg_writes++;
  endtask

  task automatic set_config(logic [INV_W-1:0] inv, logic en, logic [IDX_W-1:0] idx,
                            logic [UVAL_W-1:0] energy);
    write_reg(REG_INV_GM1, UVAL_W'(inv));
    write_reg(REG_HOT_EN, UVAL_W'(en));
    write_reg(REG_HOT_IDX, UVAL_W'(idx));
    write_reg(REG_HOT_E, energy);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (cell_q.size() != 0 || s_axis_tvalid || flux_q.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [UVAL_W-1:0] rnd63;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, register defaults
    tx_idle_pct = 12;
    rx_idle_pct = 70;
    cell_q.push_back(mk_cell('0, '0, '0, '0, '0, '0));
    cell_q.push_back(mk_cell('1, FX_ONE, FX_ONE, FX_ONE, 2 * FX_ONE, -3 * FX_ONE));
    cell_q.push_back(mk_cell(21'd5, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX));
    cell_q.push_back(mk_cell(21'd6, FX_MAX, '0, FX_MIN, FX_MIN, FX_MIN));
    cell_q.push_back(mk_cell(21'd7, FX_ONE, '0, FX_MIN, FX_MAX, '0));
    cell_q.push_back(mk_cell(21'd8, 64'sd1, 64'sd1, 64'sd8388608, -64'sd8388608,
                             64'sd8388608));
    cell_q.push_back(mk_cell(21'd9, FX_ONE, '0, 64'sd1, -64'sd1, 64'sd3));
    cell_q.push_back(mk_cell(21'd10, '0, FX_MAX, '0, '0, '0));
    cell_q.push_back(mk_cell(21'd11, 64'sd20552090, 64'sd101325 <<< FRAC_BITS,
                             10 * FX_ONE, -5 * FX_ONE, FX_ONE >>> 1));
    cell_q.push_back(mk_cell(21'd12, 64'sd3, 64'sd7, -64'sd1 <<< 50, 64'sd1 <<< 45,
                             -FX_ONE));
    drain();

    // hot cell at the top index, widest settings
    set_config('1, 1'b1, '1, '1);
    cell_q.push_back(mk_cell('1, 64'sd20552090, FX_ONE, 3 * FX_ONE, -FX_ONE, FX_ONE));
    cell_q.push_back(mk_cell(21'h1FFFFE, 64'sd20552090, FX_ONE, 3 * FX_ONE, -FX_ONE, FX_ONE));
    cell_q.push_back(mk_cell('1, FX_ONE, '0, '0, '0, '0));
    cell_q.push_back(mk_cell('0, FX_ONE, FX_ONE, -FX_ONE, FX_ONE, -FX_ONE));
    drain();

    // hot cell at index zero, zero energy and zero 1/(gamma-1)
    set_config('0, 1'b1, '0, '0);
    cell_q.push_back(mk_cell('0, FX_ONE, FX_ONE, -2 * FX_ONE, FX_ONE, 7 * FX_ONE));
    cell_q.push_back(mk_cell(21'd1, FX_ONE, FX_ONE, -2 * FX_ONE, FX_ONE, 7 * FX_ONE));
    drain();

    // random
    for (int r = 0; r < 6; r++) begin
      rnd63 = {$urandom, $urandom};
      case (r)
        0: set_config(32'd41943040, 1'b0, IDX_W'($urandom), rnd63);
        1: set_config($urandom, 1'b1, IDX_W'($urandom), rnd63 >> $urandom_range(50, 20));
        2: set_config('1, 1'b1, '1, rnd63);
        3: set_config(32'd16777216, 1'b0, '0, '0);
        4: set_config('0, 1'b1, IDX_W'($urandom), '1);
        default: set_config($urandom, 1'b1, IDX_W'($urandom), rnd63);
      endcase
      tx_idle_pct = (r < 2) ? 12 : (r < 4) ? 70 : 0;
      rx_idle_pct = (r < 2) ? 70 : (r < 4) ? 12 : 0;
      repeat (RANDOM_CELLS) cell_q.push_back(rand_cell());
      if (r == 0) begin
        // hold the source until the output has caught up
        @(negedge clk_i);
        while (cell_q.size() > RANDOM_CELLS / 2) @(negedge clk_i);
        tx_hold = 1'b1;
        while (s_axis_tvalid || flux_q.size() != 0) @(negedge clk_i);
        tx_hold = 1'b0;
      end
      drain();
    end

    repeat (RESULT_LAT + 8) @(posedge clk_i);
    if (flux_q.size() != 0) begin
      $error("%0d expected result transactions never arrived", flux_q.size());
      errors++;
    end
    $display("checked %0d cells, %0d result transactions, %0d register writes",
             cells_sent, results_seen, cfg_writes);
    $display("covered hot cell on and off, saturation, rounding ties, mixed stalls");
    if (errors == 0) begin
      $display("euler_flux_from_primitive regression: pass");
    end else begin
      $display("euler_flux_from_primitive regression: fail");
    end
    $finish;
  end

endmodule
